// File: hdl/bnpa_pkg.sv
package bnpa_pkg;

    // Fixed sizes of the node header fields and the counters.
    localparam int SLOTS_MAX      = 32;
    localparam int SLOT_W         = 5;
    localparam int ARRAY_W        = 3;
    localparam int CNT_W          = 9;
    localparam int MAX_ARRAYS_DEF = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Reset values of the configuration registers.
    localparam logic [5:0]  NODES_RST     = 6'd32;
    localparam logic [3:0]  ARRAYS_RST    = 4'd8;
    localparam logic [8:0]  THRESHOLD_RST = 9'd48;

    typedef enum logic [2:0] {
        CFG_NODES_PER_ARRAY = 3'd0,
        CFG_ARRAYS_IN_USE   = 3'd1,
        CFG_FREE_THRESHOLD  = 3'd2,
        CFG_HANDLE_MAGIC    = 3'd3,
        CFG_POOL_ID         = 3'd4,
        CFG_NODE_MAGIC      = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_POOL  = 3'd1,
        STAT_EXHAUSTED = 3'd2,
        STAT_BAD_MAGIC = 3'd3,
        STAT_BAD_SLOT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RET
    } state_t;

    // What the shared slot unit reports about one occupancy mask.
    typedef struct packed {
        logic                 found;
        logic [SLOT_W-1:0]    free_slot;
        logic                 bit_set;
        logic [SLOTS_MAX-1:0] mask_set;
        logic [SLOTS_MAX-1:0] mask_clr;
        logic                 clr_empty;
    } slot_res_t;

endpackage

// File: hdl/bnpa_slot_unit.sv
module bnpa_slot_unit
    import bnpa_pkg::*;
(
    input  logic [SLOTS_MAX-1:0] mask,
    input  logic [5:0]           n_slots,
    input  logic [SLOT_W-1:0]    slot,
    output slot_res_t            res
);

    logic [SLOTS_MAX-1:0] limit;
    logic [SLOTS_MAX-1:0] avail;
    logic [SLOTS_MAX-1:0] lowest;
    logic [SLOTS_MAX-1:0] one_hot;
    logic [SLOT_W-1:0]    enc;

    // Bits at or above the slot count count as occupied.
    assign limit  = SLOTS_MAX'(({(SLOTS_MAX+1){1'b0}} | (SLOTS_MAX+1)'(1)) << n_slots) - 1'b1;
    assign avail  = ~mask & limit;
    assign lowest = avail & (~avail + 1'b1);
    assign one_hot = SLOTS_MAX'(1) << slot;

    always_comb
    begin
        enc = '0;
        for (int b = 0; b < SLOT_W; b++)
        begin
            for (int k = 0; k < SLOTS_MAX; k++)
            begin
                if (((k >> b) & 1) == 1)
                begin
                    enc[b] = enc[b] | lowest[k];
                end
            end
        end
    end

    always_comb
    begin
        res.found     = |avail;
        res.free_slot = enc;
        res.bit_set   = |(mask & one_hot);
        res.mask_set  = mask | lowest;
        res.mask_clr  = mask & ~one_hot;
        res.clr_empty = ~|(mask & ~one_hot);
    end

endmodule

// File: hdl/bnpa_mask_ram.sv
module bnpa_mask_ram
    import bnpa_pkg::*;
#(
    parameter int DEPTH = MAX_ARRAYS_DEF,
    parameter int AW    = 3
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [SLOTS_MAX-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [SLOTS_MAX-1:0] rdata
);

    logic [SLOTS_MAX-1:0] mem [DEPTH];
    logic [SLOTS_MAX-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bitmap_node_pool_allocator_core.sv
// Sequence: a request turned away in its check state (bad handle, no
// arrays in use, bad header or index) shows done from the CHECK state; a
// checked return passes through CHECK and RET, a get through CHECK and one
// SCAN step per array it examines. Throughput: one item at a time, set by the
// one-array-per-cycle scan; a new start is taken in the cycle done is shown.
// Reset (rst_n low, asynchronous) empties the pool; the receiver cannot stall.
module bitmap_node_pool_allocator_core
    import bnpa_pkg::*;
#(
    parameter int MAX_ARRAYS = MAX_ARRAYS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [31:0]         get_handle,
    input  logic [ARRAY_W-1:0]  ret_array,
    input  logic [SLOT_W-1:0]   ret_slot,
    input  logic [15:0]         ret_pool,
    input  logic [31:0]         ret_magic,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output logic [2:0]          status,
    output logic [ARRAY_W-1:0]  got_array,
    output logic [SLOT_W-1:0]   got_slot,
    output logic                array_opened,
    output logic                array_released,
    output logic [CNT_W-1:0]    used_count
);

    // Width of an array index; one bit is kept even for a single array.
    localparam int AW = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;

    // Configuration registers. They are only written while the block is idle.
    logic [5:0]  nodes_reg;
    logic [3:0]  arrays_reg;
    logic [8:0]  thresh_reg;
    logic [15:0] hmagic_reg;
    logic [15:0] pool_id_reg;
    logic [31:0] nmagic_reg;

    // Captured request.
    logic                req_type_reg;
    logic [31:0]         handle_reg;
    logic [ARRAY_W-1:0]  ret_array_reg;
    logic [SLOT_W-1:0]   ret_slot_reg;
    logic [15:0]         ret_pool_reg;
    logic [31:0]         ret_magic_reg;

    // Sequencer and pool state. The present bits also act as valid bits for
    // the mask RAM: an array that is not present reads as an empty mask, so
    // the RAM itself never needs clearing.
    state_t                 state_reg, state_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [MAX_ARRAYS-1:0]  present_reg, present_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       alloc_reg, alloc_next;

    // Result registers.
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [ARRAY_W-1:0]  got_array_reg, got_array_next;
    logic [SLOT_W-1:0]   got_slot_reg, got_slot_next;
    logic                opened_reg, opened_next;
    logic                released_reg, released_next;

    // Effective configuration after clamping.
    logic [5:0]  n_eff;
    logic [AW:0] na_eff;

    always_comb
    begin
        if (nodes_reg == 6'd0)
        begin
            n_eff = 6'd1;
        end
        else if ({26'd0, nodes_reg} > 32'(SLOTS_MAX))
        begin
            n_eff = 6'(SLOTS_MAX);
        end
        else
        begin
            n_eff = nodes_reg;
        end
    end

    always_comb
    begin
        if ({28'd0, arrays_reg} > 32'(MAX_ARRAYS))
        begin
            na_eff = (AW+1)'(MAX_ARRAYS);
        end
        else
        begin
            na_eff = (AW+1)'(arrays_reg);
        end
    end

    // Request checks made in the CHECK state.
    logic          handle_ok;
    logic          ret_range_ok;
    logic [AW-1:0] ra_idx;
    logic          last_array;

    assign handle_ok    = (handle_reg[31:16] == hmagic_reg) && (handle_reg[15:0] == pool_id_reg);
    assign ret_range_ok = (32'(ret_array_reg) < 32'(na_eff)) &&
                          (32'(ret_slot_reg) < 32'(n_eff));
    assign ra_idx       = AW'(ret_array_reg);
    assign last_array   = (32'(idx_reg) + 32'd1) >= 32'(na_eff);

    // Mask RAM: one read per cycle with registered data, one write per item.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SLOTS_MAX-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [SLOTS_MAX-1:0] mem_rdata;

    bnpa_mask_ram #(
        .DEPTH (MAX_ARRAYS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The read is issued in the cycle before its use. In CHECK it fetches the
    // first array (get) or the returned node's array; during the scan it
    // fetches the array after the one being examined.
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            mem_raddr = idx_reg + 1'b1;
        end
        else if (req_type_reg)
        begin
            mem_raddr = ra_idx;
        end
        else
        begin
            mem_raddr = '0;
        end
    end

    // The shared slot unit looks at the mask now coming out of the RAM.
    logic [AW-1:0]        cur_idx;
    logic                 cur_present;
    logic [SLOTS_MAX-1:0] cur_mask;
    slot_res_t            su;

    assign cur_idx     = (state_reg == S_SCAN) ? idx_reg : ra_idx;
    assign cur_present = present_reg[cur_idx];
    assign cur_mask    = cur_present ? mem_rdata : '0;

    bnpa_slot_unit u_slot (
        .mask    (cur_mask),
        .n_slots (n_eff),
        .slot    (ret_slot_reg),
        .res     (su)
    );

    // Counter arithmetic. Both counters saturate at the top and at zero.
    logic [CNT_W-1:0] used_inc;
    logic [CNT_W-1:0] used_dec;
    logic [CNT_W:0]   alloc_sum;
    logic [CNT_W-1:0] alloc_add;
    logic [CNT_W-1:0] alloc_sub;
    logic [CNT_W-1:0] free_cnt;
    logic             ret_ok;
    logic             do_release;

    assign used_inc  = (used_reg == CNT_MAX) ? CNT_MAX : used_reg + 1'b1;
    assign used_dec  = (used_reg == '0) ? '0 : used_reg - 1'b1;
    assign alloc_sum = {1'b0, alloc_reg} + (CNT_W+1)'(n_eff);
    assign alloc_add = alloc_sum[CNT_W] ? CNT_MAX : alloc_sum[CNT_W-1:0];
    assign alloc_sub = (alloc_reg > CNT_W'(n_eff)) ? alloc_reg - CNT_W'(n_eff) : '0;
    assign free_cnt  = (alloc_reg > used_dec) ? alloc_reg - used_dec : '0;

    // A return is good when its array is present and the slot is occupied.
    // The array goes back once it is empty and the free slots exceed the
    // threshold.
    assign ret_ok     = cur_present && su.bit_set;
    assign do_release = su.clr_empty && (free_cnt > thresh_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (req_type_reg)
                begin
                    if ((ret_pool_reg == pool_id_reg) && (ret_magic_reg == nmagic_reg) &&
                        ret_range_ok)
                    begin
                        state_next = S_RET;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (handle_ok && (na_eff != '0))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (su.found || last_array)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RET:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result updates.
    always_comb
    begin
        idx_next       = idx_reg;
        present_next   = present_reg;
        used_next      = used_reg;
        alloc_next     = alloc_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        got_array_next = got_array_reg;
        got_slot_next  = got_slot_reg;
        opened_next    = opened_reg;
        released_next  = released_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_idx;
        mem_wdata      = su.mask_set;

        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
            end
            S_CHECK:
            begin
                got_array_next = '0;
                got_slot_next  = '0;
                opened_next    = 1'b0;
                released_next  = 1'b0;
                if (req_type_reg)
                begin
                    if (ret_pool_reg != pool_id_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_BAD_POOL;
                    end
                    else if (ret_magic_reg != nmagic_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_BAD_MAGIC;
                    end
                    else if (!ret_range_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_BAD_SLOT;
                    end
                end
                else if (!handle_ok)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_BAD_POOL;
                end
                else if (na_eff == '0)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_EXHAUSTED;
                end
            end
            S_SCAN:
            begin
                // An absent array always yields slot zero, so opening an array
                // and granting from it happen together.
                if (su.found)
                begin
                    mem_we                = 1'b1;
                    mem_wdata             = su.mask_set;
                    present_next[idx_reg] = 1'b1;
                    used_next             = used_inc;
                    if (!cur_present)
                    begin
                        alloc_next  = alloc_add;
                        opened_next = 1'b1;
                    end
                    done_next      = 1'b1;
                    status_next    = STAT_OK;
                    got_array_next = ARRAY_W'(idx_reg);
                    got_slot_next  = su.free_slot;
                end
                else if (last_array)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_EXHAUSTED;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RET:
            begin
                done_next = 1'b1;
                if (ret_ok)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = su.mask_clr;
                    used_next   = used_dec;
                    status_next = STAT_OK;
                    if (do_release)
                    begin
                        present_next[ra_idx] = 1'b0;
                        alloc_next           = alloc_sub;
                        released_next        = 1'b1;
                    end
                end
                else
                begin
                    status_next = STAT_BAD_SLOT;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            present_reg <= '0;
            used_reg    <= '0;
            alloc_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            present_reg <= present_next;
            used_reg    <= used_next;
            alloc_reg   <= alloc_next;
            done_reg    <= done_next;
        end
    end

    // Result payload needs no reset; it is qualified by done.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        got_array_reg <= got_array_next;
        got_slot_reg  <= got_slot_next;
        opened_reg    <= opened_next;
        released_reg  <= released_next;
    end

    // The request is captured when start is taken in the idle state.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            req_type_reg  <= req_type;
            handle_reg    <= get_handle;
            ret_array_reg <= ret_array;
            ret_slot_reg  <= ret_slot;
            ret_pool_reg  <= ret_pool;
            ret_magic_reg <= ret_magic;
        end
    end

    // Configuration writes. An index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg   <= NODES_RST;
            arrays_reg  <= ARRAYS_RST;
            thresh_reg  <= THRESHOLD_RST;
            hmagic_reg  <= '0;
            pool_id_reg <= '0;
            nmagic_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NODES_PER_ARRAY: nodes_reg   <= cfg_data[5:0];
                CFG_ARRAYS_IN_USE:   arrays_reg  <= cfg_data[3:0];
                CFG_FREE_THRESHOLD:  thresh_reg  <= cfg_data[8:0];
                CFG_HANDLE_MAGIC:    hmagic_reg  <= cfg_data[15:0];
                CFG_POOL_ID:         pool_id_reg <= cfg_data[15:0];
                CFG_NODE_MAGIC:      nmagic_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = (state_reg == S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign got_array      = got_array_reg;
    assign got_slot       = got_slot_reg;
    assign array_opened   = opened_reg;
    assign array_released = released_reg;
    assign used_count     = used_reg;

endmodule

// File: hdl/bnpa_checker.sv
module bnpa_checker
    import bnpa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic       array_opened,
    input logic       array_released
);

    // An accepted item keeps the block busy for the following cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an item was accepted");

    // No item completes in the cycle right after it was accepted.
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done)
        else $error("result shown too early");

    // Opening or releasing an array only happens on a successful request.
    a_flags_need_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (array_opened || array_released) |-> status == STAT_OK)
        else $error("array flag set on a failed request");

    // One request never both opens and releases an array.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(array_opened && array_released))
        else $error("array opened and released by one request");

endmodule

bind bitmap_node_pool_allocator_core bnpa_checker u_bnpa_checker (.*);

// File: dv/tb_bitmap_node_pool_allocator_core.sv
module tb_bitmap_node_pool_allocator_core;
    import bnpa_pkg::*;

    // Generous end of run, far beyond the slowest correct run.
    localparam int TIMEOUT_LIMIT    = 2000000;
    localparam int PHASE_COUNT      = 6;
    localparam int ITEMS_PER_PHASE  = 310;
    // A get may scan every array plus decode and update; this covers it.
    localparam int SETTLE_CYCLES    = MAX_ARRAYS_DEF + 6;

    // One request item as presented on the input ports.
    typedef struct packed {
        logic                req_type;
        logic [31:0]         get_handle;
        logic [ARRAY_W-1:0]  ret_array;
        logic [SLOT_W-1:0]   ret_slot;
        logic [15:0]         ret_pool;
        logic [31:0]         ret_magic;
    } node_req_t;

    localparam int REQ_W = $bits(node_req_t);

    // One reply item as shown on the result ports with done.
    typedef struct packed {
        status_t             status;
        logic [ARRAY_W-1:0]  got_array;
        logic [SLOT_W-1:0]   got_slot;
        logic                array_opened;
        logic                array_released;
        logic [CNT_W-1:0]    used_count;
    } node_res_t;

    // A row of the directed table: either a register write or a request,
    // the latter optionally with its reply typed in by hand.
    typedef struct packed {
        logic       is_cfg;
        cfg_idx_t   idx;
        logic [31:0] data;
        node_req_t  req;
        logic       typed;
        node_res_t  res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [31:0]         get_handle;
    logic [ARRAY_W-1:0]  ret_array;
    logic [SLOT_W-1:0]   ret_slot;
    logic [15:0]         ret_pool;
    logic [31:0]         ret_magic;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;
    logic                done;
    logic [2:0]          status;
    logic [ARRAY_W-1:0]  got_array;
    logic [SLOT_W-1:0]   got_slot;
    logic                array_opened;
    logic                array_released;
    logic [CNT_W-1:0]    used_count;

    // Shadow copy of the pool: occupancy, present flags and the two counters.
    logic [SLOTS_MAX-1:0] shadow_mask [MAX_ARRAYS_DEF];
    logic                 shadow_present [MAX_ARRAYS_DEF];
    int unsigned          shadow_used;
    int unsigned          shadow_alloc;

    // Shadow copy of the configuration registers.
    logic [5:0]  cur_nodes;
    logic [3:0]  cur_arrays;
    logic [8:0]  cur_threshold;
    logic [15:0] cur_hmagic;
    logic [15:0] cur_pool;
    logic [31:0] cur_nmagic;

    node_res_t replies_due [$];
    dir_row_t  dir_rows [$];

    int errors;
    int idle_pct;
    int quiet_left;
    int get_pct;

    always #2 clk = ~clk;

    bitmap_node_pool_allocator_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .get_handle     (get_handle),
        .ret_array      (ret_array),
        .ret_slot       (ret_slot),
        .ret_pool       (ret_pool),
        .ret_magic      (ret_magic),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .got_array      (got_array),
        .got_slot       (got_slot),
        .array_opened   (array_opened),
        .array_released (array_released),
        .used_count     (used_count)
    );

    // Computes the reply to one request and advances the shadow pool, exactly
    // as the block is meant to: handle check, in-order scan with opening of
    // absent arrays, and the header checks and release rule on a return.
    function automatic node_res_t apply_pool_request(node_req_t r);
        node_res_t   res;
        int unsigned n;
        int unsigned na;
        int unsigned free_slots;
        int          s;
        bit          granted;
        res = '0;
        // Out-of-range slot and array counts are clamped to what exists.
        n  = (cur_nodes == 0) ? 1 : (cur_nodes > SLOTS_MAX) ? SLOTS_MAX : cur_nodes;
        na = (cur_arrays > MAX_ARRAYS_DEF) ? MAX_ARRAYS_DEF : cur_arrays;
        if (!r.req_type)
        begin
            if (r.get_handle != {cur_hmagic, cur_pool})
            begin
                res.status = STAT_BAD_POOL;
            end
            else
            begin
                res.status = STAT_EXHAUSTED;
                granted = 1'b0;
                for (int i = 0; i < na && !granted; i++)
                begin
                    if (!shadow_present[i])
                    begin
                        shadow_present[i] = 1'b1;
                        shadow_mask[i]    = '0;
                        shadow_alloc = (shadow_alloc + n > CNT_MAX) ? CNT_MAX : shadow_alloc + n;
                        res.array_opened = 1'b1;
                    end
                    s = -1;
                    for (int b = int'(n) - 1; b >= 0; b--)
                    begin
                        if (!shadow_mask[i][b]) s = b;
                    end
                    if (s >= 0)
                    begin
                        shadow_mask[i][s] = 1'b1;
                        if (shadow_used < CNT_MAX) shadow_used++;
                        res.status    = STAT_OK;
                        res.got_array = ARRAY_W'(i);
                        res.got_slot  = SLOT_W'(s);
                        granted       = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (r.ret_pool != cur_pool)
            begin
                res.status = STAT_BAD_POOL;
            end
            else if (r.ret_magic != cur_nmagic)
            begin
                res.status = STAT_BAD_MAGIC;
            end
            else if (r.ret_array >= na || r.ret_slot >= n ||
                     !shadow_present[r.ret_array] ||
                     !shadow_mask[r.ret_array][r.ret_slot])
            begin
                res.status = STAT_BAD_SLOT;
            end
            else
            begin
                shadow_mask[r.ret_array][r.ret_slot] = 1'b0;
                if (shadow_used > 0) shadow_used--;
                free_slots = (shadow_alloc > shadow_used) ? shadow_alloc - shadow_used : 0;
                if (shadow_mask[r.ret_array] == '0 && free_slots > cur_threshold)
                begin
                    shadow_present[r.ret_array] = 1'b0;
                    shadow_alloc = (shadow_alloc > n) ? shadow_alloc - n : 0;
                    res.array_released = 1'b1;
                end
            end
        end
        res.used_count = shadow_used[CNT_W-1:0];
        return res;
    endfunction

    function automatic node_res_t mk_res(status_t st, int unsigned arr, int unsigned slot,
                                         bit opened, bit released, int unsigned used);
        node_res_t res;
        res.status         = st;
        res.got_array      = ARRAY_W'(arr);
        res.got_slot       = SLOT_W'(slot);
        res.array_opened   = opened;
        res.array_released = released;
        res.used_count     = CNT_W'(used);
        return res;
    endfunction

    // Builders for request items; the fields that the request kind ignores
    // are filled with noise so that every input bit keeps toggling.
    function automatic node_req_t get_req(logic [31:0] handle);
        node_req_t r;
        r            = REQ_W'({$urandom, $urandom, $urandom});
        r.req_type   = 1'b0;
        r.get_handle = handle;
        return r;
    endfunction

    function automatic node_req_t ret_req(int unsigned arr, int unsigned slot,
                                          logic [15:0] pool, logic [31:0] magic);
        node_req_t r;
        r           = REQ_W'({$urandom, $urandom, $urandom});
        r.req_type  = 1'b1;
        r.ret_array = ARRAY_W'(arr);
        r.ret_slot  = SLOT_W'(slot);
        r.ret_pool  = pool;
        r.ret_magic = magic;
        return r;
    endfunction

    function automatic void add_row(node_req_t r);
        dir_row_t row;
        row     = '0;
        row.req = r;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(node_req_t r, node_res_t x);
        dir_row_t row;
        row       = '0;
        row.req   = r;
        row.typed = 1'b1;
        row.res   = x;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(cfg_idx_t idx, logic [31:0] data);
        dir_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        dir_rows.push_back(row);
    endfunction

    // Random request: mostly well-formed gets and returns of slots that are
    // really held, so the pool fills, empties and releases arrays; the rest
    // is bad handles, bad headers, stray indices and pure noise.
    function automatic node_req_t make_pool_request();
        node_req_t   r;
        int unsigned cand_a [$];
        int unsigned cand_s [$];
        int unsigned pick;
        r = REQ_W'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 99) < 88)
        begin
            if ($urandom_range(0, 99) < get_pct)
            begin
                r.req_type   = 1'b0;
                r.get_handle = {cur_hmagic, cur_pool};
            end
            else
            begin
                for (int a = 0; a < MAX_ARRAYS_DEF; a++)
                begin
                    for (int s = 0; s < SLOTS_MAX; s++)
                    begin
                        if (shadow_present[a] && shadow_mask[a][s])
                        begin
                            cand_a.push_back(a);
                            cand_s.push_back(s);
                        end
                    end
                end
                r.req_type  = 1'b1;
                r.ret_pool  = cur_pool;
                r.ret_magic = cur_nmagic;
                if (cand_a.size() != 0)
                begin
                    pick        = $urandom_range(0, cand_a.size() - 1);
                    r.ret_array = ARRAY_W'(cand_a[pick]);
                    r.ret_slot  = SLOT_W'(cand_s[pick]);
                end
            end
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    r.req_type   = 1'b0;
                    r.get_handle = {cur_hmagic, cur_pool} ^ (32'h1 << $urandom_range(0, 31));
                end
                1:
                begin
                    r.req_type = 1'b1;
                    r.ret_pool = cur_pool ^ 16'($urandom_range(1, 65535));
                end
                2:
                begin
                    r.req_type  = 1'b1;
                    r.ret_pool  = cur_pool;
                    r.ret_magic = cur_nmagic ^ (32'h1 << $urandom_range(0, 31));
                end
                3:
                begin
                    r.req_type  = 1'b1;
                    r.ret_pool  = cur_pool;
                    r.ret_magic = cur_nmagic;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Presents one item, holds it until the block takes it, then records the
    // reply that is due. Inputs only change at falling edges; start is either
    // kept high for the next item or dropped for a gap, never both at once.
    task automatic issue_request(node_req_t r, bit typed, node_res_t typed_res);
        node_res_t want;
        if (idle_pct > 0 && quiet_left == 0)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start       <= 1'b1;
        req_type    <= r.req_type;
        get_handle  <= r.get_handle;
        ret_array   <= r.ret_array;
        ret_slot    <= r.ret_slot;
        ret_pool    <= r.ret_pool;
        ret_magic   <= r.ret_magic;
        do @(posedge clk); while (busy);
        want = apply_pool_request(r);
        if (typed) want = typed_res;
        replies_due.push_back(want);
        // Now and then a stretch of back-to-back items with no gaps at all.
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 99) < 3) quiet_left = $urandom_range(15, 40);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_NODES_PER_ARRAY: cur_nodes     = data[5:0];
            CFG_ARRAYS_IN_USE:   cur_arrays    = data[3:0];
            CFG_FREE_THRESHOLD:  cur_threshold = data[8:0];
            CFG_HANDLE_MAGIC:    cur_hmagic    = data[15:0];
            CFG_POOL_ID:         cur_pool      = data[15:0];
            CFG_NODE_MAGIC:      cur_nmagic    = data[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops issuing, waits for every reply due, then lets the block drain.
    task automatic settle_pool();
        @(negedge clk);
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reply checker: every done must match the oldest reply due, field by field.
    always @(posedge clk)
    begin
        node_res_t want;
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: reply with none due, expected nothing, actual status %0d",
                         $time, status);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", want.status, status);
                check_field("got_array", want.got_array, got_array);
                check_field("got_slot", want.got_slot, got_slot);
                check_field("array_opened", want.array_opened, array_opened);
                check_field("array_released", want.array_released, array_released);
                check_field("used_count", want.used_count, used_count);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        node_req_t r;
        // Every input is known from time zero, while reset is held low.
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = 1'b0;
        get_handle  = '0;
        ret_array   = '0;
        ret_slot    = '0;
        ret_pool    = '0;
        ret_magic   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        quiet_left  = 0;
        get_pct     = 60;
        idle_pct    = 29;

        // The shadow starts from the reset state of the block.
        cur_nodes     = NODES_RST;
        cur_arrays    = ARRAYS_RST;
        cur_threshold = THRESHOLD_RST;
        cur_hmagic    = '0;
        cur_pool      = '0;
        cur_nmagic    = '0;
        shadow_used   = 0;
        shadow_alloc  = 0;
        for (int a = 0; a < MAX_ARRAYS_DEF; a++)
        begin
            shadow_mask[a]    = '0;
            shadow_present[a] = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Straight after reset the replies are obvious: the
        // first get opens array zero, each header check fails in its order,
        // and returning the only slot leaves too few free slots to release.
        add_typed(get_req(32'h0000_0000), mk_res(STAT_OK, 0, 0, 1, 0, 1));
        add_typed(get_req(32'hFFFF_0000), mk_res(STAT_BAD_POOL, 0, 0, 0, 0, 1));
        add_typed(get_req(32'h0000_FFFF), mk_res(STAT_BAD_POOL, 0, 0, 0, 0, 1));
        add_typed(ret_req(0, 0, 16'h0001, 32'h0), mk_res(STAT_BAD_POOL, 0, 0, 0, 0, 1));
        add_typed(ret_req(0, 0, 16'h0, 32'hFFFF_FFFF), mk_res(STAT_BAD_MAGIC, 0, 0, 0, 0, 1));
        add_typed(ret_req(0, 31, 16'h0, 32'h0), mk_res(STAT_BAD_SLOT, 0, 0, 0, 0, 1));
        add_typed(ret_req(7, 0, 16'h0, 32'h0), mk_res(STAT_BAD_SLOT, 0, 0, 0, 0, 1));
        add_typed(ret_req(0, 0, 16'h0, 32'h0), mk_res(STAT_OK, 0, 0, 0, 0, 0));

        // A zero slot count acts as one slot per array; two arrays, release
        // whenever any slot is free, and all-ones handle and header words.
        add_cfg(CFG_NODES_PER_ARRAY, 32'd0);
        add_cfg(CFG_ARRAYS_IN_USE, 32'd2);
        add_cfg(CFG_FREE_THRESHOLD, 32'd0);
        add_cfg(CFG_HANDLE_MAGIC, 32'h0000_FFFF);
        add_cfg(CFG_POOL_ID, 32'h0000_FFFF);
        add_cfg(CFG_NODE_MAGIC, 32'hFFFF_FFFF);
        add_row(get_req(32'hFFFF_FFFF));
        add_row(get_req(32'hFFFF_FFFF));
        add_row(get_req(32'hFFFF_FFFF));
        add_row(get_req(32'h0000_0000));
        add_row(ret_req(0, 1, 16'hFFFF, 32'hFFFF_FFFF));
        add_row(ret_req(2, 0, 16'hFFFF, 32'hFFFF_FFFF));
        add_row(ret_req(0, 0, 16'hFFFF, 32'hFFFF_FFFF));
        add_row(ret_req(1, 0, 16'hFFFF, 32'hFFFF_FFFF));

        // With no arrays in use every get is exhausted.
        add_cfg(CFG_ARRAYS_IN_USE, 32'd0);
        add_typed(get_req(32'hFFFF_FFFF), mk_res(STAT_EXHAUSTED, 0, 0, 0, 0, 0));

        // Counts above their limits are clamped; the largest threshold.
        add_cfg(CFG_ARRAYS_IN_USE, 32'hFFFF_FFFF);
        add_cfg(CFG_NODES_PER_ARRAY, 32'hFFFF_FFFF);
        add_cfg(CFG_FREE_THRESHOLD, 32'hFFFF_FFFF);
        add_row(get_req(32'hFFFF_FFFF));
        add_row(get_req(32'hFFFF_FFFF));
        add_row(get_req(32'hFFFF_FFFF));
        add_row(ret_req(7, 31, 16'hFFFF, 32'hFFFF_FFFF));
        add_row(ret_req(0, 31, 16'hFFFF, 32'hFFFF_FFFF));
        add_row(ret_req(0, 0, 16'hFFFF, 32'hFFFF_FFFF));

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].is_cfg)
            begin
                settle_pool();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end
            else
            begin
                issue_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
            end
        end

        // Random part, in phases of different settings. The pool state is
        // carried across phases, so slot and array counts change under
        // arrays that are already open.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle_pool();
            case (p)
                0:
                begin
                    write_reg(CFG_NODES_PER_ARRAY, 32'd4);
                    write_reg(CFG_ARRAYS_IN_USE, 32'd3);
                    write_reg(CFG_FREE_THRESHOLD, 32'd0);
                end
                1:
                begin
                    write_reg(CFG_NODES_PER_ARRAY, 32'd32);
                    write_reg(CFG_ARRAYS_IN_USE, 32'd8);
                    write_reg(CFG_FREE_THRESHOLD, 32'd48);
                end
                2:
                begin
                    write_reg(CFG_NODES_PER_ARRAY, 32'd1);
                    write_reg(CFG_ARRAYS_IN_USE, 32'd8);
                    write_reg(CFG_FREE_THRESHOLD, 32'd2);
                end
                3:
                begin
                    write_reg(CFG_NODES_PER_ARRAY, 32'd7);
                    write_reg(CFG_ARRAYS_IN_USE, 32'd15);
                    write_reg(CFG_FREE_THRESHOLD, 32'd511);
                end
                4:
                begin
                    write_reg(CFG_NODES_PER_ARRAY, 32'd63);
                    write_reg(CFG_ARRAYS_IN_USE, 32'd1);
                    write_reg(CFG_FREE_THRESHOLD, 32'd256);
                end
                default:
                begin
                    write_reg(CFG_NODES_PER_ARRAY, $urandom_range(0, 63));
                    write_reg(CFG_ARRAYS_IN_USE, $urandom_range(1, 15));
                    write_reg(CFG_FREE_THRESHOLD, $urandom_range(0, 40));
                end
            endcase
            if (p == 1)
            begin
                write_reg(CFG_HANDLE_MAGIC, 32'h0);
                write_reg(CFG_POOL_ID, 32'h0);
                write_reg(CFG_NODE_MAGIC, 32'h0);
            end
            else if (p == 3)
            begin
                write_reg(CFG_HANDLE_MAGIC, 32'hFFFF);
                write_reg(CFG_POOL_ID, 32'hFFFF);
                write_reg(CFG_NODE_MAGIC, 32'hFFFF_FFFF);
            end
            else
            begin
                write_reg(CFG_HANDLE_MAGIC, $urandom_range(0, 65535));
                write_reg(CFG_POOL_ID, $urandom_range(0, 65535));
                write_reg(CFG_NODE_MAGIC, $urandom);
            end

            // Sender gaps: light at first, heavy next, none at the end.
            idle_pct = (p < 2) ? 29 : (p < 4) ? 63 : 0;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // The mix of gets and returns drifts so the pool both fills
                // up to exhaustion and drains down to releases.
                if (k % 40 == 0) get_pct = $urandom_range(20, 85);
                r = make_pool_request();
                issue_request(r, 1'b0, '0);
            end
        end

        settle_pool();
        if (errors == 0 && replies_due.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
